// ----- sv/flrw_pkg.sv -----
// Shared types and constants for the flash ring log writer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package flrw_pkg;

	localparam int BASE_W       = 24;
	localparam int SECTORS_W    = 13;
	localparam int LEN_W        = 9;
	localparam int OFF_W        = 8;
	localparam int USED_W       = 25;
	localparam int CNT_W        = 2;
	localparam int RESULT_LIMIT = 3;
	localparam int APB_DW       = 32;
	localparam int APB_AW       = 3;

	localparam logic [SECTORS_W-1:0] SECTORS_RESET = 13'd256;

	// register index as decoded from paddr
	localparam logic REG_BASE    = 1'b0;
	localparam logic REG_SECTORS = 1'b1;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_CLEAR   = 2'd1,
		MODE_RESTORE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_ERASE   = 2'd1,
		CMD_PROGRAM = 2'd2
	} flash_cmd_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic restore_head;
		logic restore_tail;
		logic erase;
		logic size;
		logic advance;
		logic set_none;
		logic emit;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       len_zero;
		logic       aligned;
		logic       more;
		logic       n_full;
		logic       out_free;
	} dp_status_t;

endpackage

// ----- sv/flrw_datapath.sv -----
// Datapath: configuration registers, log pointers, request and result registers.
// Depends on flrw_pkg; driven by flrw_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module flrw_datapath #(
	parameter int SECTOR_BYTES    = 4096,
	parameter int PAGE_BYTES      = 256,
	parameter int MAX_WRITE_BYTES = 256,
	parameter int ADDRESS_BITS    = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  flrw_pkg::dp_cmd_t                 cmd,
	output flrw_pkg::dp_status_t              status,
	input  logic                              cfg_we,
	input  logic                              cfg_sel,
	input  logic [flrw_pkg::APB_DW-1:0]       cfg_wdata,
	output logic [flrw_pkg::APB_DW-1:0]       cfg_rdata,
	input  logic [1:0]                        mode,
	input  logic [flrw_pkg::LEN_W-1:0]        length,
	input  logic [flrw_pkg::BASE_W-1:0]       restore_head,
	input  logic                              restore_wrapped,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [1:0]                        command,
	output logic [flrw_pkg::BASE_W-1:0]       flash_address,
	output logic [flrw_pkg::OFF_W-1:0]        buffer_offset,
	output logic [flrw_pkg::LEN_W-1:0]        chunk_length,
	output logic [flrw_pkg::USED_W-1:0]       used_bytes,
	output logic                              last
);
	import flrw_pkg::*;

	localparam int SEC_SHIFT  = $clog2(SECTOR_BYTES);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int SPAN_W     = SECTORS_W + SEC_SHIFT;
	localparam int EW         = ((BASE_W > SPAN_W) ? BASE_W : SPAN_W) + 1;
	localparam int MASK_BITS  = (ADDRESS_BITS < BASE_W) ? ADDRESS_BITS : BASE_W;
	localparam logic [BASE_W-1:0] ADDR_MASK   = {BASE_W{1'b1}} >> (BASE_W - MASK_BITS);
	localparam logic [EW-1:0]     SECTOR_SIZE = EW'(SECTOR_BYTES);
	localparam logic [EW-1:0]     PAGE_SIZE   = EW'(PAGE_BYTES);
	localparam logic [LEN_W-1:0]  MAX_LEN     = LEN_W'(MAX_WRITE_BYTES);
	localparam logic [EW-1:0]     END_RESET   = EW'(SECTORS_RESET) << SEC_SHIFT;

	logic [BASE_W-1:0]    base_q;
	logic [SECTORS_W-1:0] sectors_q;
	logic [EW-1:0]        end_q;
	logic [EW-1:0]        head_q;
	logic [EW-1:0]        tail_q;
	logic                 wrapped_q;

	logic [1:0]           mode_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     off_q;
	logic [CNT_W-1:0]     n_q;
	logic [BASE_W-1:0]    rhead_q;
	logic                 rwrap_q;
	logic [LEN_W-1:0]     chunk_q;

	flash_cmd_t           res_cmd_q;
	logic [BASE_W-1:0]    res_addr_q;
	logic [OFF_W-1:0]     res_boff_q;
	logic [LEN_W-1:0]     res_clen_q;

	logic                 out_valid_q;
	logic [1:0]           out_cmd_q;
	logic [BASE_W-1:0]    out_addr_q;
	logic [OFF_W-1:0]     out_boff_q;
	logic [LEN_W-1:0]     out_clen_q;
	logic [USED_W-1:0]    out_used_q;
	logic                 out_last_q;

	logic [SECTORS_W-1:0] sectors_eff;
	logic [EW-1:0]        end_next;
	logic [EW-1:0]        base_ext;
	logic [BASE_W-1:0]    new_base;
	logic [EW-1:0]        rh;
	logic                 r_at_end;
	logic                 r_outside;
	logic [SEC_SHIFT-1:0] low_diff;
	logic [EW-1:0]        tail_cand;
	logic [EW-1:0]        tail_next;
	logic [LEN_W-1:0]     rem;
	logic [EW-1:0]        to_page;
	logic [EW-1:0]        to_sector;
	logic [EW-1:0]        to_end;
	logic [EW-1:0]        c1;
	logic [EW-1:0]        c2;
	logic [EW-1:0]        c3;
	logic [EW-1:0]        adv;
	logic [EW-1:0]        used_full;

	// region geometry
	assign sectors_eff = (sectors_q == '0) ? SECTORS_W'(1) : sectors_q;
	assign end_next    = EW'(base_q) + (EW'(sectors_eff) << SEC_SHIFT);
	assign base_ext    = EW'(base_q);
	assign new_base    = (cfg_sel == REG_BASE) ? (cfg_wdata[BASE_W-1:0] & ADDR_MASK) : base_q;

	// restore checks
	assign rh        = EW'(rhead_q);
	assign r_at_end  = (rh == end_q);
	assign r_outside = (rh < base_ext) || (rh > end_q);

	// tail moves to the next sector start; restore aligns relative to the base
	assign low_diff  = head_q[SEC_SHIFT-1:0] - base_q[SEC_SHIFT-1:0];
	assign tail_cand = cmd.erase ? (head_q + SECTOR_SIZE)
	                             : (head_q - EW'(low_diff) + SECTOR_SIZE);
	assign tail_next = (tail_cand >= end_q) ? base_ext : tail_cand;

	// chunk sizing: remaining, page end, sector end, region end
	assign rem       = len_q - off_q;
	assign to_page   = PAGE_SIZE - EW'(head_q[PAGE_SHIFT-1:0]);
	assign to_sector = SECTOR_SIZE - EW'(head_q[SEC_SHIFT-1:0]);
	assign to_end    = end_q - head_q;
	assign c1        = (EW'(rem) > to_page) ? to_page : EW'(rem);
	assign c2        = (c1 > to_sector) ? to_sector : c1;
	assign c3        = (c2 > to_end) ? to_end : c2;

	assign adv = head_q + EW'(chunk_q);

	always_comb begin
		if (!wrapped_q) begin
			used_full = head_q - base_ext;
		end else if (head_q >= tail_q) begin
			used_full = head_q - tail_q;
		end else begin
			used_full = (end_q - tail_q) + (head_q - base_ext);
		end
	end

	assign status.mode     = mode_q;
	assign status.len_zero = (len_q == '0);
	assign status.aligned  = (head_q[SEC_SHIFT-1:0] == '0);
	assign status.more     = (off_q < len_q);
	assign status.n_full   = (n_q == CNT_W'(RESULT_LIMIT));
	assign status.out_free = !out_valid_q || out_ready;

	assign cfg_rdata = (cfg_sel == REG_BASE) ? APB_DW'(base_q) : APB_DW'(sectors_q);

	// configuration and log pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			sectors_q <= SECTORS_RESET;
			end_q     <= END_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			wrapped_q <= 1'b0;
		end else begin
			end_q <= end_next;
			if (cfg_we) begin
				if (cfg_sel == REG_BASE) begin
					base_q <= new_base;
				end else begin
					sectors_q <= cfg_wdata[SECTORS_W-1:0];
				end
				head_q    <= EW'(new_base);
				tail_q    <= EW'(new_base);
				wrapped_q <= 1'b0;
			end else if (cmd.clear) begin
				head_q    <= base_ext;
				tail_q    <= base_ext;
				wrapped_q <= 1'b0;
			end else if (cmd.restore_head) begin
				if (r_at_end) begin
					head_q    <= base_ext;
					wrapped_q <= 1'b1;
				end else begin
					head_q    <= r_outside ? base_ext : rh;
					wrapped_q <= rwrap_q;
				end
			end else if (cmd.restore_tail) begin
				tail_q <= wrapped_q ? tail_next : base_ext;
			end else if (cmd.erase) begin
				if (wrapped_q) begin
					tail_q <= tail_next;
				end
			end else if (cmd.advance) begin
				if (adv >= end_q) begin
					head_q    <= base_ext;
					wrapped_q <= 1'b1;
				end else begin
					head_q <= adv;
				end
			end
		end
	end

	// request progress and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				off_q <= '0;
				n_q   <= '0;
			end else if (cmd.erase) begin
				n_q <= n_q + CNT_W'(1);
			end else if (cmd.advance) begin
				off_q <= off_q + chunk_q;
				n_q   <= n_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			len_q   <= (length > MAX_LEN) ? MAX_LEN : length;
			rhead_q <= restore_head & ADDR_MASK;
			rwrap_q <= restore_wrapped;
		end
		if (cmd.size) begin
			chunk_q <= c3[LEN_W-1:0];
		end
		if (cmd.set_none) begin
			res_cmd_q  <= CMD_NONE;
			res_addr_q <= '0;
			res_boff_q <= '0;
			res_clen_q <= '0;
		end else if (cmd.erase) begin
			res_cmd_q  <= CMD_ERASE;
			res_addr_q <= head_q[BASE_W-1:0] & ADDR_MASK;
			res_boff_q <= '0;
			res_clen_q <= '0;
		end else if (cmd.advance) begin
			res_cmd_q  <= CMD_PROGRAM;
			res_addr_q <= head_q[BASE_W-1:0] & ADDR_MASK;
			res_boff_q <= off_q[OFF_W-1:0];
			res_clen_q <= chunk_q;
		end
		if (cmd.emit) begin
			out_cmd_q  <= res_cmd_q;
			out_addr_q <= res_addr_q;
			out_boff_q <= res_boff_q;
			out_clen_q <= res_clen_q;
			out_used_q <= used_full[USED_W-1:0];
			out_last_q <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign command       = out_cmd_q;
	assign flash_address = out_addr_q;
	assign buffer_offset = out_boff_q;
	assign chunk_length  = out_clen_q;
	assign used_bytes    = out_used_q;
	assign last          = out_last_q;

endmodule

// ----- sv/flrw_ctrl.sv -----
// Controller: sequences erase and program steps for each request.
// Depends on flrw_pkg; drives flrw_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module flrw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  flrw_pkg::dp_status_t status,
	output flrw_pkg::dp_cmd_t    cmd
);
	import flrw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RTAIL,
		S_SIZE,
		S_ADV,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		P_NONE,
		P_ERASE,
		P_PROG
	} pend_t;

	state_t state_q;
	state_t state_d;
	pend_t  pend_q;
	pend_t  pend_d;
	logic   is_last;

	always_comb begin
		unique case (pend_q)
			P_NONE:  is_last = 1'b1;
			P_ERASE: is_last = status.n_full;
			P_PROG:  is_last = !status.more || status.n_full;
			default: is_last = 1'b1;
		endcase
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		pend_d   = pend_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (mode_t'(status.mode))
					MODE_CLEAR: begin
						cmd.clear    = 1'b1;
						cmd.set_none = 1'b1;
						pend_d       = P_NONE;
						state_d      = S_EMIT;
					end
					MODE_RESTORE: begin
						cmd.restore_head = 1'b1;
						state_d          = S_RTAIL;
					end
					MODE_WRITE: begin
						if (status.len_zero) begin
							cmd.set_none = 1'b1;
							pend_d       = P_NONE;
							state_d      = S_EMIT;
						end else if (status.aligned) begin
							cmd.erase = 1'b1;
							pend_d    = P_ERASE;
							state_d   = S_EMIT;
						end else begin
							state_d = S_SIZE;
						end
					end
					default: begin
						cmd.set_none = 1'b1;
						pend_d       = P_NONE;
						state_d      = S_EMIT;
					end
				endcase
			end
			S_RTAIL: begin
				cmd.restore_tail = 1'b1;
				cmd.set_none     = 1'b1;
				pend_d           = P_NONE;
				state_d          = S_EMIT;
			end
			S_SIZE: begin
				cmd.size = 1'b1;
				state_d  = S_ADV;
			end
			S_ADV: begin
				cmd.advance = 1'b1;
				pend_d      = P_PROG;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = is_last;
					// after an erase the chunk follows without a new boundary check
					if (is_last) begin
						state_d = S_IDLE;
					end else if (pend_q == P_ERASE) begin
						state_d = S_SIZE;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= P_NONE;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ----- sv/flash_ring_log_writer.sv -----
// Top level of the flash ring log writer: APB register port, request and result channels.
// Depends on flrw_pkg, flrw_ctrl and flrw_datapath.
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_ready   mode, length, restore_head, restore_wrapped
//   result    out        out_valid / out_ready command, flash_address, buffer_offset,
//                                              chunk_length, used_bytes, last
//   config    in         psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// One request at a time. Clear, unknown mode and empty write: accept, execute step, emit
// step. Restore adds a tail step. A write takes an execute step with the erase and an emit per
// erase, and boundary check, chunk sizing, pointer advance and emit per program chunk; a chunk
// that follows an erase skips the boundary check. The sequencer steps through one shared sizing
// and pointer datapath.
// Reset puts both pointers at base 0 with 256 sectors and the wrapped flag clear.
// The emit step stalls while the result register is full and out_ready is low; a new request
// is taken while the last result of the previous one is still waiting.
`timescale 1ns / 1ps

module flash_ring_log_writer #(
	parameter int SECTOR_BYTES    = 4096,
	parameter int PAGE_BYTES      = 256,
	parameter int MAX_WRITE_BYTES = 256,
	parameter int ADDRESS_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [flrw_pkg::APB_AW-1:0]   paddr,
	input  logic [flrw_pkg::APB_DW-1:0]   pwdata,
	output logic [flrw_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [flrw_pkg::LEN_W-1:0]    length,
	input  logic [flrw_pkg::BASE_W-1:0]   restore_head,
	input  logic                          restore_wrapped,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    command,
	output logic [flrw_pkg::BASE_W-1:0]   flash_address,
	output logic [flrw_pkg::OFF_W-1:0]    buffer_offset,
	output logic [flrw_pkg::LEN_W-1:0]    chunk_length,
	output logic [flrw_pkg::USED_W-1:0]   used_bytes,
	output logic                          last
);
	import flrw_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;
	logic       cfg_we;
	logic       cfg_sel;

	// register transfer completes in the access phase; pready is always high
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_sel = paddr[2];

	flrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	flrw_datapath #(
		.SECTOR_BYTES    (SECTOR_BYTES),
		.PAGE_BYTES      (PAGE_BYTES),
		.MAX_WRITE_BYTES (MAX_WRITE_BYTES),
		.ADDRESS_BITS    (ADDRESS_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.status          (dp_status),
		.cfg_we          (cfg_we),
		.cfg_sel         (cfg_sel),
		.cfg_wdata       (pwdata),
		.cfg_rdata       (prdata),
		.mode            (mode),
		.length          (length),
		.restore_head    (restore_head),
		.restore_wrapped (restore_wrapped),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.command         (command),
		.flash_address   (flash_address),
		.buffer_offset   (buffer_offset),
		.chunk_length    (chunk_length),
		.used_bytes      (used_bytes),
		.last            (last)
	);

endmodule

// ----- verif/flash_ring_log_writer_tb.sv -----
// Self-checking testbench for the flash ring log writer: APB setup, request driver, result monitor.
// Predicts the erase/program command stream and the used-byte count of the circular log.
// Depends on flrw_pkg and flash_ring_log_writer.
`timescale 1ns / 1ps

module flash_ring_log_writer_tb;
	import flrw_pkg::*;

	localparam longint unsigned SECTOR_BYTES    = 4096;
	localparam longint unsigned PAGE_BYTES      = 256;
	localparam longint unsigned MAX_WRITE_BYTES = 256;
	localparam logic [1:0]      MODE_UNKNOWN    = 2'd3;
	localparam int              IDLE_PCT        = 33;
	localparam int              HOLD_CYCLES     = 250;
	localparam int              SETTLE_CYCLES   = 16;
	localparam int              MAX_REPORTS     = 40;

	typedef struct {
		logic [1:0]  mode;
		logic [8:0]  len;
		logic [23:0] head;
		logic        wrapped;
	} log_req_t;

	typedef struct {
		flash_cmd_t  cmd;
		logic [23:0] addr;
		logic [7:0]  boff;
		logic [8:0]  clen;
		logic [24:0] used;
		logic        last;
	} flash_op_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          mode = '0;
	logic [LEN_W-1:0]    length = '0;
	logic [BASE_W-1:0]   restore_head = '0;
	logic                restore_wrapped = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          command;
	logic [BASE_W-1:0]   flash_address;
	logic [OFF_W-1:0]    buffer_offset;
	logic [LEN_W-1:0]    chunk_length;
	logic [USED_W-1:0]   used_bytes;
	logic                last;

	flash_ring_log_writer uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .length(length),
		.restore_head(restore_head), .restore_wrapped(restore_wrapped),
		.out_valid(out_valid), .out_ready(out_ready), .command(command),
		.flash_address(flash_address), .buffer_offset(buffer_offset),
		.chunk_length(chunk_length), .used_bytes(used_bytes), .last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// log pointer model
	longint unsigned cfg_base = 0;
	longint unsigned cfg_sectors = 256;
	longint unsigned ring_head = 0;
	longint unsigned ring_tail = 0;
	bit              ring_wrapped = 1'b0;

	log_req_t  pending_reqs[$];
	flash_op_t expected_ops[$];
	log_req_t  cur_req;
	int        error_count = 0;
	bit        no_gaps = 1'b0;
	int        hold_token = 0;
	int        hold_seen = 0;
	int        hold_left = 0;

	function automatic longint unsigned region_limit();
		longint unsigned nsec;
		nsec = (cfg_sectors == 0) ? 1 : cfg_sectors;
		return cfg_base + nsec * SECTOR_BYTES;
	endfunction

	function automatic longint unsigned used_count();
		if (!ring_wrapped)
			return ring_head - cfg_base;
		if (ring_head >= ring_tail)
			return ring_head - ring_tail;
		return (region_limit() - ring_tail) + (ring_head - cfg_base);
	endfunction

	function automatic flash_op_t make_op(flash_cmd_t cmd, longint unsigned dest,
			longint unsigned boff, longint unsigned clen);
		flash_op_t op;
		op.cmd  = cmd;
		op.addr = 24'(dest);
		op.boff = 8'(boff);
		op.clen = 9'(clen);
		op.used = 25'(used_count());
		op.last = 1'b0;
		return op;
	endfunction

	function automatic void set_region(logic idx, longint unsigned value);
		if (idx == REG_BASE)
			cfg_base = value & 64'hFF_FFFF;
		else
			cfg_sectors = value & 64'h1FFF;
		ring_head = cfg_base;
		ring_tail = cfg_base;
		ring_wrapped = 1'b0;
	endfunction

	// Works out the command stream for one accepted request.
	function automatic void predict_request(log_req_t rq);
		flash_op_t       ops[$];
		flash_op_t       op;
		longint unsigned fin, h, t, len, off, chunk, dest;
		bit              w;
		fin = region_limit();
		if (rq.mode == MODE_CLEAR) begin
			ring_head = cfg_base;
			ring_tail = cfg_base;
			ring_wrapped = 1'b0;
		end else if (rq.mode == MODE_RESTORE) begin
			h = rq.head;
			w = rq.wrapped;
			if (h == fin) begin
				h = cfg_base;
				w = 1'b1;
			end else if (h < cfg_base || h > fin) begin
				h = cfg_base;
			end
			ring_head = h;
			ring_wrapped = w;
			if (w) begin
				t = cfg_base + ((h - cfg_base) / SECTOR_BYTES) * SECTOR_BYTES + SECTOR_BYTES;
				ring_tail = (t >= fin) ? cfg_base : t;
			end else begin
				ring_tail = cfg_base;
			end
		end else if (rq.mode == MODE_WRITE) begin
			len = (rq.len > MAX_WRITE_BYTES) ? MAX_WRITE_BYTES : rq.len;
			off = 0;
			while (off < len && ops.size() < RESULT_LIMIT) begin
				if (ring_head % SECTOR_BYTES == 0) begin
					// erase ahead of the head; a wrapped log loses its oldest sector
					if (ring_wrapped) begin
						t = ring_head + SECTOR_BYTES;
						ring_tail = (t >= fin) ? cfg_base : t;
					end
					ops.push_back(make_op(CMD_ERASE, ring_head, 0, 0));
					if (ops.size() >= RESULT_LIMIT)
						break;
				end
				chunk = len - off;
				if (chunk > PAGE_BYTES - ring_head % PAGE_BYTES)
					chunk = PAGE_BYTES - ring_head % PAGE_BYTES;
				if (chunk > SECTOR_BYTES - ring_head % SECTOR_BYTES)
					chunk = SECTOR_BYTES - ring_head % SECTOR_BYTES;
				if (chunk > fin - ring_head)
					chunk = fin - ring_head;
				dest = ring_head;
				ring_head += chunk;
				if (ring_head >= fin) begin
					ring_head = cfg_base;
					ring_wrapped = 1'b1;
				end
				ops.push_back(make_op(CMD_PROGRAM, dest, off, chunk));
				off += chunk;
			end
		end
		if (ops.size() == 0)
			ops.push_back(make_op(CMD_NONE, 0, 0, 0));
		for (int i = 0; i < ops.size(); i++) begin
			op = ops[i];
			op.last = (i == ops.size() - 1);
			expected_ops.push_back(op);
		end
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_request(cur_req);
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
					cur_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					mode <= cur_req.mode;
					length <= cur_req.len;
					restore_head <= cur_req.head;
					restore_wrapped <= cur_req.wrapped;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_ops.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: result transfer with nothing expected, expected none, actual %0h",
							$time, flash_address);
				end else begin
					check_field("command", expected_ops[0].cmd, command);
					check_field("flash_address", expected_ops[0].addr, flash_address);
					check_field("buffer_offset", expected_ops[0].boff, buffer_offset);
					check_field("chunk_length", expected_ops[0].clen, chunk_length);
					check_field("used_bytes", expected_ops[0].used, used_bytes);
					check_field("last", expected_ops[0].last, last);
					void'(expected_ops.pop_front());
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// APB write followed by a read-back; only called while the block is idle
	task automatic write_reg(logic idx, longint unsigned value);
		longint unsigned want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		set_region(idx, value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		want = (idx == REG_BASE) ? cfg_base : cfg_sectors;
		check_field("prdata", want, prdata);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void add_req(logic [1:0] md, logic [8:0] len, logic [23:0] h, logic w);
		log_req_t rq;
		rq.mode = md;
		rq.len = len;
		rq.head = h;
		rq.wrapped = w;
		pending_reqs.push_back(rq);
	endfunction

	task automatic drain();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_ops.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void queue_random(int count);
		longint unsigned nsec, span, h;
		int r, sel;
		nsec = (cfg_sectors == 0) ? 1 : cfg_sectors;
		span = nsec * SECTOR_BYTES;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				sel = $urandom_range(0, 9);
				if (sel == 0)
					add_req(MODE_WRITE, 9'd0, 24'($urandom), 1'($urandom));
				else if (sel == 1)
					add_req(MODE_WRITE, 9'($urandom_range(257, 511)), 24'($urandom), 1'($urandom));
				else
					add_req(MODE_WRITE, 9'($urandom_range(1, 256)), 24'($urandom), 1'($urandom));
			end else if (r < 87) begin
				sel = $urandom_range(0, 9);
				if (sel < 3)
					h = cfg_base + $urandom_range(0, 32'(span - 1));
				else if (sel < 6)
					// just short of a sector end: program, erase, program
					h = cfg_base + $urandom_range(0, 32'(nsec - 1)) * SECTOR_BYTES
						+ SECTOR_BYTES - $urandom_range(1, 255);
				else if (sel < 8)
					h = $urandom;
				else if (sel == 8)
					h = cfg_base + span;
				else
					h = cfg_base - 1;
				add_req(MODE_RESTORE, 9'($urandom), 24'(h), 1'($urandom));
			end else if (r < 93) begin
				add_req(MODE_CLEAR, 9'($urandom), 24'($urandom), 1'($urandom));
			end else begin
				add_req(MODE_UNKNOWN, 9'($urandom), 24'($urandom), 1'($urandom));
			end
		end
	endfunction

	task automatic random_phase(int count);
		int nsec, pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			nsec = $urandom_range(1, 4);
		else if (pick < 9)
			nsec = $urandom_range(5, 64);
		else
			nsec = $urandom_range(65, 4096);
		write_reg(REG_SECTORS, nsec);
		write_reg(REG_BASE, longint'($urandom_range(0, 4096 - nsec)) * SECTOR_BYTES);
		queue_random(count);
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: base 0, 256 sectors
		add_req(MODE_WRITE, 9'd0, 24'hFFFFFF, 1'b1);
		add_req(MODE_WRITE, 9'd1, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd255, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd300, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd511, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd100, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_UNKNOWN, 9'd511, 24'hFFFFFF, 1'b1);
		add_req(MODE_CLEAR, 9'd0, 24'h0, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'h0FFF00, 1'b1);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd64, 24'h0, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'h100000, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'hFFFFFF, 1'b1);
		add_req(MODE_RESTORE, 9'd0, 24'h001F80, 1'b1);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'h000800, 1'b0);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_CLEAR, 9'd0, 24'h0, 1'b0);
		drain();

		// one sector at the top of the address space
		write_reg(REG_SECTORS, 1);
		write_reg(REG_BASE, 24'hFFF000);
		add_req(MODE_RESTORE, 9'd0, 24'h000010, 1'b0);
		repeat (18) add_req(MODE_WRITE, 9'd250, 24'h0, 1'b0);
		drain();

		// zero sectors behaves as one
		write_reg(REG_SECTORS, 0);
		write_reg(REG_BASE, 24'h002000);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'h002F80, 1'b1);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'h003000, 1'b0);
		drain();

		// whole address space
		write_reg(REG_BASE, 0);
		write_reg(REG_SECTORS, 4096);
		add_req(MODE_RESTORE, 9'd0, 24'hFFFF00, 1'b1);
		add_req(MODE_WRITE, 9'd256, 24'h0, 1'b0);
		add_req(MODE_WRITE, 9'd16, 24'h0, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'hFFFFFF, 1'b0);
		add_req(MODE_WRITE, 9'd1, 24'h0, 1'b0);
		add_req(MODE_RESTORE, 9'd0, 24'h000000, 1'b1);
		add_req(MODE_WRITE, 9'd200, 24'h0, 1'b0);
		drain();

		random_phase(46);
		no_gaps = 1'b1;
		random_phase(46);
		no_gaps = 1'b0;
		// receiver stalls long enough for the request side to back up
		hold_token++;
		random_phase(46);
		random_phase(46);
		random_phase(46);

		if (error_count == 0 && expected_ops.size() == 0)
			$display("flash_ring_log_writer_tb passed");
		else
			$display("flash_ring_log_writer_tb failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("flash_ring_log_writer_tb failed");
		$finish;
	end

endmodule
